// ----- sv/lob_pkg.sv -----
package lob_pkg;

  // Default number of resting orders per side.
  localparam int LOB_DEPTH = 32;

  localparam logic SIDE_BUY  = 1'b0;
  localparam logic SIDE_SELL = 1'b1;

  localparam logic [1:0] ST_RESTED   = 2'd0;
  localparam logic [1:0] ST_FILLED   = 2'd1;
  localparam logic [1:0] ST_REJECTED = 2'd2;

  // One incoming limit order.
  typedef struct packed {
    logic        sell;
    logic [15:0] price;
    logic [15:0] qty;
  } order_t;

  // Commands from the matching engine to one side's book.
  typedef struct packed {
    logic        ins;
    logic        pop;
    logic        wr_qty;
    logic [15:0] price;
    logic [15:0] qty;
    logic [15:0] id;
  } book_ctl_t;

  // What a book shows of itself: fill state and its best entry.
  typedef struct packed {
    logic        empty;
    logic        full;
    logic [15:0] price;
    logic [15:0] qty;
    logic [15:0] id;
  } book_view_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_INSERT,
    S_MATCH,
    S_STATUS
  } eng_state_t;

endpackage

// ----- sv/limit_order_book_matcher_top.sv -----
// Limit order book matcher. Each input item is one limit order (side in tuser,
// price and quantity in tdata). It receives the next order id, is inserted into
// its side's sorted book, and is then matched against the opposite book one
// trade per cycle while the result side is free to take it. Every trade leaves
// as one result item, followed by a status item with tlast set. The engine's
// sequencer works one order at a time while a two-entry queue keeps taking
// input. When its own side already holds BOOK_DEPTH orders, an order is
// rejected with status 2 and only the status item is sent.
module limit_order_book_matcher_top
  import lob_pkg::*;
#(
  parameter int BOOK_DEPTH = LOB_DEPTH
)(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // limit_price[15:0], order_qty[31:16]
  input  logic        s_tuser,   // side
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata,   // buy_order_id, sell_order_id, trade_price,
                                 // trade_qty, new_order_id, status[81:80], zero pad
  output logic        m_tuser,   // is_trade
  output logic        m_tlast    // last
);

  order_t     in_order;
  order_t     q_head;
  logic       q_full;
  logic       q_valid;
  logic       q_pop;
  book_ctl_t  bid_ctl;
  book_ctl_t  ask_ctl;
  book_view_t bid_view;
  book_view_t ask_view;

  logic [15:0] o_buy_id;
  logic [15:0] o_sell_id;
  logic [15:0] o_price;
  logic [15:0] o_qty;
  logic [15:0] o_new_id;
  logic [1:0]  o_status;

  // Unpack the incoming item.
  assign in_order.sell  = s_tuser;
  assign in_order.price = s_tdata[15:0];
  assign in_order.qty   = s_tdata[31:16];
  assign s_tready       = !q_full;

  lob_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (s_tvalid),
    .push_data (in_order),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  lob_book #(.Depth(BOOK_DEPTH), .Ascend(1'b0)) u_bids (
    .clk  (clk),
    .rst  (rst),
    .ctl  (bid_ctl),
    .view (bid_view)
  );

  lob_book #(.Depth(BOOK_DEPTH), .Ascend(1'b1)) u_asks (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ask_ctl),
    .view (ask_view)
  );

  lob_engine #(.Depth(BOOK_DEPTH)) u_engine (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .bid_view     (bid_view),
    .ask_view     (ask_view),
    .bid_ctl      (bid_ctl),
    .ask_ctl      (ask_ctl),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_is_trade (m_tuser),
    .out_buy_id   (o_buy_id),
    .out_sell_id  (o_sell_id),
    .out_price    (o_price),
    .out_qty      (o_qty),
    .out_new_id   (o_new_id),
    .out_status   (o_status),
    .out_last     (m_tlast)
  );

  // Pack the result item.
  assign m_tdata = {6'd0, o_status, o_new_id, o_qty, o_price, o_sell_id, o_buy_id};

endmodule

// ----- sv/lob_queue.sv -----
module lob_queue
  import lob_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  order_t push_data,
  output logic   full,
  input  logic   pop,
  output logic   valid,
  output order_t head
);

  // Two-entry queue that parts the input side from the matching engine.
  order_t     mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign valid = (count != 2'd0);
  assign head  = mem[rd_ptr];

  // Storage is written without reset.
  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && !full) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop && valid) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push && !full, pop && valid})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- sv/lob_book.sv -----
module lob_book
  import lob_pkg::*;
#(
  parameter int  Depth  = LOB_DEPTH,
  parameter bit  Ascend = 1'b0
)(
  input  logic       clk,
  input  logic       rst,
  input  book_ctl_t  ctl,
  output book_view_t view
);

  localparam int CW = $clog2(Depth + 1);

  // Sorted row of entries; entry 0 is the best. Each entry only sees its neighbours.
  logic [15:0]   pr  [Depth];
  logic [15:0]   qt  [Depth];
  logic [15:0]   ids [Depth];
  logic [CW-1:0] count;
  logic [Depth-1:0] stay;

  // An entry stays in place on insertion if it ranks at or ahead of the new price.
  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      stay[i] = (CW'(i) < count) &&
                (Ascend ? (pr[i] <= ctl.price) : (pr[i] >= ctl.price));
    end
  end

  // Insertion shifts the tail down one place; a pop shifts everything up; a quantity write updates entry 0.
  always_ff @(posedge clk) begin
    for (int i = 0; i < Depth; i++) begin
      if (ctl.ins) begin
        if (!stay[i]) begin
          if (i == 0 || stay[(i == 0) ? 0 : i - 1]) begin
            pr[i]  <= ctl.price;
            qt[i]  <= ctl.qty;
            ids[i] <= ctl.id;
          end else begin
            pr[i]  <= pr[(i == 0) ? 0 : i - 1];
            qt[i]  <= qt[(i == 0) ? 0 : i - 1];
            ids[i] <= ids[(i == 0) ? 0 : i - 1];
          end
        end
      end else if (ctl.pop) begin
        if (i < Depth - 1) begin
          pr[i]  <= pr[(i < Depth - 1) ? i + 1 : i];
          qt[i]  <= qt[(i < Depth - 1) ? i + 1 : i];
          ids[i] <= ids[(i < Depth - 1) ? i + 1 : i];
        end
      end else if (ctl.wr_qty && i == 0) begin
        qt[i] <= ctl.qty;
      end
    end
  end

  // Number of resting orders.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.ins) begin
      count <= count + CW'(1);
    end else if (ctl.pop) begin
      count <= count - CW'(1);
    end
  end

  assign view.empty = (count == '0);
  assign view.full  = (count >= CW'(Depth));
  assign view.price = pr[0];
  assign view.qty   = qt[0];
  assign view.id    = ids[0];

endmodule

// ----- sv/lob_engine.sv -----
module lob_engine
  import lob_pkg::*;
#(
  parameter int Depth = LOB_DEPTH
)(
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  order_t      q_head,
  output logic        q_pop,
  input  book_view_t  bid_view,
  input  book_view_t  ask_view,
  output book_ctl_t   bid_ctl,
  output book_ctl_t   ask_ctl,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_is_trade,
  output logic [15:0] out_buy_id,
  output logic [15:0] out_sell_id,
  output logic [15:0] out_price,
  output logic [15:0] out_qty,
  output logic [15:0] out_new_id,
  output logic [1:0]  out_status,
  output logic        out_last
);

  localparam int CW = $clog2(Depth + 1);

  eng_state_t    st, st_next;
  order_t        cur;
  logic [15:0]   next_id;
  logic [15:0]   nid;
  logic [15:0]   rem;
  logic [CW-1:0] trades;
  logic          reject;

  logic        out_free;
  logic        crossed;
  logic        own_full;
  logic [15:0] t;
  logic        emit_trade;
  logic        emit_status;
  logic        accept_order;

  assign out_free = !out_valid || out_ready;
  assign crossed  = !bid_view.empty && !ask_view.empty &&
                    (bid_view.price >= ask_view.price) && (trades < CW'(Depth));
  assign own_full = (cur.sell == SIDE_SELL) ? ask_view.full : bid_view.full;
  assign t        = (bid_view.qty < ask_view.qty) ? bid_view.qty : ask_view.qty;

  // Next state.
  always_comb begin
    st_next = st;
    unique case (st)
      S_IDLE:   if (q_valid) st_next = S_INSERT;
      S_INSERT: st_next = own_full ? S_STATUS : S_MATCH;
      S_MATCH:  if (!crossed) st_next = S_STATUS;
      S_STATUS: if (out_free) st_next = S_IDLE;
      default:  st_next = S_IDLE;
    endcase
  end

  // Commands to the queue and the books.
  always_comb begin
    q_pop        = (st == S_IDLE) && q_valid;
    accept_order = (st == S_INSERT) && !own_full;
    emit_trade   = (st == S_MATCH) && crossed && out_free;
    emit_status  = (st == S_STATUS) && out_free;
    bid_ctl      = '0;
    ask_ctl      = '0;
    bid_ctl.price = cur.price;
    bid_ctl.id    = next_id;
    ask_ctl.price = cur.price;
    ask_ctl.id    = next_id;
    bid_ctl.qty   = cur.qty;
    ask_ctl.qty   = cur.qty;
    if (accept_order) begin
      bid_ctl.ins = (cur.sell == SIDE_BUY);
      ask_ctl.ins = (cur.sell == SIDE_SELL);
    end
    if (emit_trade) begin
      bid_ctl.qty    = bid_view.qty - t;
      ask_ctl.qty    = ask_view.qty - t;
      bid_ctl.pop    = (bid_view.qty == t);
      ask_ctl.pop    = (ask_view.qty == t);
      bid_ctl.wr_qty = (bid_view.qty != t);
      ask_ctl.wr_qty = (ask_view.qty != t);
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      st      <= S_IDLE;
      next_id <= 16'd1;
      reject  <= 1'b0;
    end else begin
      st <= st_next;
      if (st == S_INSERT) begin
        reject <= own_full;
        if (!own_full) begin
          next_id <= next_id + 16'd1;
        end
      end
    end
  end

  // Order being worked and its running totals.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_head;
    end
    if (st == S_INSERT) begin
      nid    <= next_id;
      rem    <= cur.qty;
      trades <= '0;
    end else if (emit_trade) begin
      trades <= trades + CW'(1);
      rem    <= rem - ((rem < t) ? rem : t);
    end
  end

  // Output register, free to load whenever it is empty or being taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_trade || emit_status) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_trade) begin
      out_is_trade <= 1'b1;
      out_buy_id   <= bid_view.id;
      out_sell_id  <= ask_view.id;
      out_price    <= ask_view.price;
      out_qty      <= t;
      out_new_id   <= nid;
      out_status   <= ST_RESTED;
      out_last     <= 1'b0;
    end else if (emit_status) begin
      out_is_trade <= 1'b0;
      out_buy_id   <= 16'd0;
      out_sell_id  <= 16'd0;
      out_price    <= 16'd0;
      out_qty      <= 16'd0;
      out_new_id   <= nid;
      out_last     <= 1'b1;
      if (reject) begin
        out_status <= ST_REJECTED;
      end else if ((trades != '0) && (rem == 16'd0)) begin
        out_status <= ST_FILLED;
      end else begin
        out_status <= ST_RESTED;
      end
    end
  end

endmodule

// ----- sv/lob_checker.sv -----
module lob_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [87:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);

  // A result item that is held back stays offered.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result item withdrawn while stalled");

  // The closing item of an order is never a trade.
  a_last_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> !m_tuser)
    else $error("status item flagged as a trade");

  // Every item before the closing one is a trade.
  a_trade_body: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tuser)
    else $error("non-final item is not a trade");

  // Trades carry a zero status and no padding bits.
  a_trade_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> (m_tdata[87:80] == 8'd0))
    else $error("trade item with non-zero status");

  // Nothing is offered straight after reset.
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result offered after reset");

endmodule

bind limit_order_book_matcher_top lob_checker u_lob_checker (.*);
